// ===== hdl/lumaedge_pkg.sv =====
// ----------------------------------------------------------------------------
// lumaedge_pkg
// Shared types and constants of the 3x3 luma edge threshold block.
// ----------------------------------------------------------------------------
package lumaedge_pkg;

  localparam int MAX_COLUMNS = 2048;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);

  localparam int COLS_W  = 12;
  localparam int ROWS_W  = 16;
  localparam int THR_W   = 8;
  localparam int GREY_W  = 8;
  localparam int OCOL_W  = 11;
  localparam int CFG_DW  = 16;
  localparam int CFG_IW  = 2;
  localparam int MIN_DIM = 3;

  localparam int COLS_RESET = 640;
  localparam int ROWS_RESET = 480;
  localparam int THR_RESET  = 16;

  // grey = floor((30r + 59g + 11b) / 100), the division done by reciprocal
  localparam int GREY_WR    = 30;
  localparam int GREY_WG    = 59;
  localparam int GREY_WB    = 11;
  localparam int SUM_W      = 15;
  localparam int GREY_MUL   = 41944;
  localparam int GREY_SHIFT = 22;
  localparam int PROD_W     = 31;

  localparam int LS_W = 2 * GREY_W;

  typedef enum logic [CFG_IW-1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_t;

  // line store access: one read and one write port
  typedef struct packed {
    logic              rd_en;
    logic [COL_AW-1:0] rd_addr;
    logic              wr_en;
    logic [COL_AW-1:0] wr_addr;
    logic [LS_W-1:0]   wr_data;
  } ls_req_t;

endpackage

// ===== hdl/lumaedge_if.sv =====
// ----------------------------------------------------------------------------
// lumaedge channels
// Valid/ready channels for pixel words in and edge result words out.
// ----------------------------------------------------------------------------
interface lumaedge_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface lumaedge_res_if;
  logic        valid;
  logic        ready;
  logic        edge_black;
  logic [15:0] out_row;
  logic [10:0] out_col;
  logic        frame_last;

  modport source (output valid, output edge_black, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input edge_black, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

// ===== hdl/luma_edge_threshold_3x3_top.sv =====
// ----------------------------------------------------------------------------
// luma_edge_threshold_3x3_top
// Streaming 3x3 neighbor-difference edge marker on a raster rgb pixel stream.
// ----------------------------------------------------------------------------
// Takes one rgb pixel word per clock while the output does not stall and
// returns one result word for each interior pixel, once its lower-right
// neighbor has arrived; border pixels give no word. A result is registered
// through s1, s2, s3 and the output register. The sustained rate is one pixel
// per clock, set by the line store, which does one read (at acceptance) and
// one write-back per pixel. Output stalls hold the whole pipeline. Writing the
// column or row count restarts the frame at row 0, column 0; the line stores
// keep their contents and need no clearing pass after reset.
module luma_edge_threshold_3x3_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lumaedge_pix_if.sink                         in_pix,
  lumaedge_res_if.source                       out_res,
  input  logic                                 cfg_wr_en,
  input  logic [lumaedge_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [lumaedge_pkg::CFG_DW-1:0]      cfg_data
);

  localparam int CW = lumaedge_pkg::COL_AW;
  localparam int KW = lumaedge_pkg::COLS_W;
  localparam int RW = lumaedge_pkg::ROWS_W;
  localparam int GW = lumaedge_pkg::GREY_W;

  // configuration
  logic [KW-1:0]                  cols_r;
  logic [RW-1:0]                  rows_r;
  logic [lumaedge_pkg::THR_W-1:0] thr_r;
  logic [KW-1:0]                  cols_eff;
  logic [RW-1:0]                  rows_eff;
  logic                           geom_wr;

  // raster position
  logic [CW-1:0] col_r, col_nxt, c_cur;
  logic [RW-1:0] row_r, row_nxt, r_cur;
  logic [KW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          emit_cur;
  logic          last_cur;

  // pipeline
  logic          en;
  logic          acc;
  logic          s1_vld_r, s1_emit_r, s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s2_vld_r, s2_emit_r, s2_last_r;
  logic [CW-1:0] s2_col_r;
  logic [RW-1:0] s2_row_r;
  logic [GW-1:0] s2_up_r, s2_mid_r;
  logic          s3_vld_r, s3_last_r;
  logic [CW-1:0] s3_col_r;
  logic [RW-1:0] s3_row_r;
  logic          out_vld_r, out_edge_r, out_last_r;
  logic [RW-1:0] out_row_r;
  logic [lumaedge_pkg::OCOL_W-1:0] out_col_r;

  logic [GW-1:0] grey;
  logic [GW-1:0] win_r [9];
  logic          edge_any;

  lumaedge_pkg::ls_req_t            ls_req;
  logic [lumaedge_pkg::LS_W-1:0]    ls_rd;

  // ---------------------------------------------------------------- config
  always_comb begin
    geom_wr = 1'b0;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        lumaedge_pkg::CFG_COLS,
        lumaedge_pkg::CFG_ROWS: geom_wr = 1'b1;
        default:                geom_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= KW'(lumaedge_pkg::COLS_RESET);
      rows_r <= RW'(lumaedge_pkg::ROWS_RESET);
      thr_r  <= lumaedge_pkg::THR_W'(lumaedge_pkg::THR_RESET);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lumaedge_pkg::CFG_COLS:   cols_r <= cfg_data[KW-1:0];
        lumaedge_pkg::CFG_ROWS:   rows_r <= cfg_data[RW-1:0];
        lumaedge_pkg::CFG_THRESH: thr_r  <= cfg_data[lumaedge_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cols_r < KW'(lumaedge_pkg::MIN_DIM)) begin
      cols_eff = KW'(lumaedge_pkg::MIN_DIM);
    end else if (cols_r > KW'(lumaedge_pkg::MAX_COLUMNS)) begin
      cols_eff = KW'(lumaedge_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = cols_r;
    end
  end

  assign rows_eff = (rows_r < RW'(lumaedge_pkg::MIN_DIM)) ? RW'(lumaedge_pkg::MIN_DIM) : rows_r;

  // ---------------------------------------------------------------- position
  assign en  = !out_vld_r || out_res.ready;
  assign acc = in_pix.valid && en;
  assign in_pix.ready = en;

  always_comb begin
    c_cur = (KW'(col_r) >= cols_eff) ? '0 : col_r;
    r_cur = (row_r >= rows_eff) ? '0 : row_r;
    col_inc = KW'(c_cur) + KW'(1);
    row_inc = {1'b0, r_cur} + (RW+1)'(1);
    if (col_inc >= cols_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, rows_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = r_cur;
    end
    emit_cur = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    last_cur = (r_cur == rows_eff - RW'(1)) && (KW'(c_cur) == cols_eff - KW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (geom_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------- datapath
  lumaedge_grey u_grey (
    .clk   (clk),
    .en    (en),
    .red   (in_pix.red),
    .green (in_pix.green),
    .blue  (in_pix.blue),
    .grey  (grey)
  );

  // a column is written back from s2 before its next read, which comes at least three words later
  always_comb begin
    ls_req.rd_en   = acc;
    ls_req.rd_addr = c_cur;
    ls_req.wr_en   = en && s2_vld_r;
    ls_req.wr_addr = s2_col_r;
    ls_req.wr_data = {s2_mid_r, grey};
  end

  lumaedge_line_store u_line_store (
    .clk     (clk),
    .req     (ls_req),
    .rd_data (ls_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= acc;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r && s2_emit_r;
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col_r   <= c_cur;
      s1_row_r   <= r_cur;
      s1_emit_r  <= emit_cur;
      s1_last_r  <= last_cur;
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      s2_emit_r  <= s1_emit_r;
      s2_last_r  <= s1_last_r;
      s2_up_r    <= ls_rd[lumaedge_pkg::LS_W-1:GW];
      s2_mid_r   <= ls_rd[GW-1:0];
      s3_col_r   <= s2_col_r;
      s3_row_r   <= s2_row_r;
      s3_last_r  <= s2_last_r;
      out_edge_r <= edge_any;
      out_row_r  <= s3_row_r - RW'(1);
      out_col_r  <= lumaedge_pkg::OCOL_W'(s3_col_r - CW'(1));
      out_last_r <= s3_last_r;
    end
  end

  // window: index 3*row + col, row 0 oldest, column 2 newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (en && s2_vld_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[3*k]     <= win_r[3*k + 1];
        win_r[3*k + 1] <= win_r[3*k + 2];
      end
      win_r[2] <= s2_up_r;
      win_r[5] <= s2_mid_r;
      win_r[8] <= grey;
    end
  end

  always_comb begin
    logic [GW-1:0] diff;
    edge_any = 1'b0;
    for (int k = 0; k < 9; k++) begin
      diff = (win_r[4] > win_r[k]) ? (win_r[4] - win_r[k]) : (win_r[k] - win_r[4]);
      if ((k != 4) && (diff > thr_r)) begin
        edge_any = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- output
  assign out_res.valid      = out_vld_r;
  assign out_res.edge_black = out_edge_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.frame_last = out_last_r;

endmodule

// ===== hdl/lumaedge_line_store.sv =====
// ----------------------------------------------------------------------------
// lumaedge_line_store
// Two rows of grey values, one entry per column: {upper, middle}.
// ----------------------------------------------------------------------------
module lumaedge_line_store (
  input  logic                               clk,
  input  lumaedge_pkg::ls_req_t              req,
  output logic [lumaedge_pkg::LS_W-1:0]      rd_data
);

  logic [lumaedge_pkg::LS_W-1:0] mem [lumaedge_pkg::MAX_COLUMNS];
  logic [lumaedge_pkg::LS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds while no new pixel is taken
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lumaedge_grey.sv =====
// ----------------------------------------------------------------------------
// lumaedge_grey
// Two-stage rgb to grey conversion: weighted sum, then reciprocal multiply.
// ----------------------------------------------------------------------------
module lumaedge_grey (
  input  logic                              clk,
  input  logic                              en,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  output logic [lumaedge_pkg::GREY_W-1:0]   grey
);

  logic [lumaedge_pkg::SUM_W-1:0]  sum_nxt;
  logic [lumaedge_pkg::SUM_W-1:0]  sum_r;
  logic [lumaedge_pkg::PROD_W-1:0] prod_r;

  assign sum_nxt = ({7'd0, red}   * lumaedge_pkg::SUM_W'(lumaedge_pkg::GREY_WR))
                 + ({7'd0, green} * lumaedge_pkg::SUM_W'(lumaedge_pkg::GREY_WG))
                 + ({7'd0, blue}  * lumaedge_pkg::SUM_W'(lumaedge_pkg::GREY_WB));

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      prod_r <= {{(lumaedge_pkg::PROD_W - lumaedge_pkg::SUM_W){1'b0}}, sum_r}
              * lumaedge_pkg::PROD_W'(lumaedge_pkg::GREY_MUL);
    end
  end

  // exact floor division by 100 for every sum below 25501
  assign grey = prod_r[lumaedge_pkg::GREY_SHIFT +: lumaedge_pkg::GREY_W];

endmodule
